// ===== hw/rtl/sts_pkg.sv =====
// ============================================================================
// sts_pkg : shared types and constants for the Taylor-series sine block
// Fixed-point constants, datapath operation codes, control and status
// structs, the divisor function and the microprogram ROM.
// ============================================================================
package sts_pkg;

    localparam int WORD_W = 64;
    localparam int WFRAC  = 59;
    localparam int ACC_W  = 98;   // holds p00 + (p01 + p10) << 32
    localparam int DIV_W  = 10;   // (2k)(2k+1) for k up to 15
    localparam int KIDX_W = 4;
    localparam int UPC_W  = 5;
    localparam int ARG_W  = 3;

    // pi and two pi in unsigned Q8.56, rounded from the true value
    localparam logic [WORD_W-1:0] PI_Q56     = 64'h03243F6A8885A309;
    localparam logic [WORD_W-1:0] TWO_PI_Q56 = 64'h06487ED5110B4612;
    // 1.0 in Q4.59
    localparam logic [WORD_W-1:0] ONE_W      = 64'h0800000000000000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RED_TEST,
        OP_RED_SUB,
        OP_RED_FIN,
        OP_MUL_PP,
        OP_MUL_RND,
        OP_Y_INIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_S_UPD,
        OP_S_ABS,
        OP_OUT_RND,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        SRC_SQ,
        SRC_TERM,
        SRC_FIN
    } src_t;

    typedef enum logic [1:0] {
        J_SEQ,
        J_RED_SMALL,
        J_DIV_MORE,
        J_K_MORE
    } jcond_t;

    typedef struct packed {
        op_t                op;
        logic [ARG_W-1:0]   arg;
        src_t               src;
        jcond_t             jc;
        logic [UPC_W-1:0]   jaddr;
        logic               last;
    } ucode_t;

    typedef struct packed {
        logic               load;
        op_t                op;
        logic [ARG_W-1:0]   arg;
        src_t               src;
    } ctrl_t;

    typedef struct packed {
        logic red_small;
        logic div_more;
        logic k_more;
    } stat_t;

    // microprogram entry points
    localparam logic [UPC_W-1:0] A_RED_TEST = 5'd0;
    localparam logic [UPC_W-1:0] A_RED_SUB  = 5'd1;
    localparam logic [UPC_W-1:0] A_RED_FIN  = 5'd6;
    localparam logic [UPC_W-1:0] A_SQ       = 5'd7;
    localparam logic [UPC_W-1:0] A_SQ_RND   = 5'd11;
    localparam logic [UPC_W-1:0] A_Y_INIT   = 5'd12;
    localparam logic [UPC_W-1:0] A_LOOP     = 5'd13;
    localparam logic [UPC_W-1:0] A_DIV_STEP = 5'd14;
    localparam logic [UPC_W-1:0] A_TERM_MUL = 5'd15;
    localparam logic [UPC_W-1:0] A_TERM_RND = 5'd19;
    localparam logic [UPC_W-1:0] A_S_UPD    = 5'd20;
    localparam logic [UPC_W-1:0] A_S_ABS    = 5'd21;
    localparam logic [UPC_W-1:0] A_FIN_MUL  = 5'd22;
    localparam logic [UPC_W-1:0] A_FIN_RND  = 5'd26;
    localparam logic [UPC_W-1:0] A_OUT_RND  = 5'd27;
    localparam logic [UPC_W-1:0] A_OUT      = 5'd28;

    function automatic logic [DIV_W-1:0] divisor(input logic [KIDX_W-1:0] k);
        logic [DIV_W-1:0] ev;
        logic [DIV_W-1:0] od;
        ev = DIV_W'({k, 1'b0});
        od = DIV_W'({k, 1'b1});
        return ev * od;
    endfunction

    function automatic ucode_t uw(input op_t op, input logic [ARG_W-1:0] arg,
                                  input src_t src, input jcond_t jc,
                                  input logic [UPC_W-1:0] jaddr, input logic last);
        ucode_t w;
        w.op    = op;
        w.arg   = arg;
        w.src   = src;
        w.jc    = jc;
        w.jaddr = jaddr;
        w.last  = last;
        return w;
    endfunction

    function automatic ucode_t urom(input logic [UPC_W-1:0] a);
        ucode_t w;
        case (a)
            A_RED_TEST:        w = uw(OP_RED_TEST, 3'd0, SRC_SQ, J_RED_SMALL, A_SQ, 1'b0);
            A_RED_SUB:         w = uw(OP_RED_SUB, 3'd4, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_RED_SUB + 5'd1:  w = uw(OP_RED_SUB, 3'd3, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_RED_SUB + 5'd2:  w = uw(OP_RED_SUB, 3'd2, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_RED_SUB + 5'd3:  w = uw(OP_RED_SUB, 3'd1, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_RED_SUB + 5'd4:  w = uw(OP_RED_SUB, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_RED_FIN:         w = uw(OP_RED_FIN, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_SQ:              w = uw(OP_MUL_PP, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_SQ + 5'd1:       w = uw(OP_MUL_PP, 3'd1, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_SQ + 5'd2:       w = uw(OP_MUL_PP, 3'd2, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_SQ + 5'd3:       w = uw(OP_MUL_PP, 3'd3, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_SQ_RND:          w = uw(OP_MUL_RND, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_Y_INIT:          w = uw(OP_Y_INIT, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_LOOP:            w = uw(OP_DIV_INIT, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b0);
            A_DIV_STEP:        w = uw(OP_DIV_STEP, 3'd0, SRC_SQ, J_DIV_MORE, A_DIV_STEP, 1'b0);
            A_TERM_MUL:        w = uw(OP_MUL_PP, 3'd0, SRC_TERM, J_SEQ, A_RED_TEST, 1'b0);
            A_TERM_MUL + 5'd1: w = uw(OP_MUL_PP, 3'd1, SRC_TERM, J_SEQ, A_RED_TEST, 1'b0);
            A_TERM_MUL + 5'd2: w = uw(OP_MUL_PP, 3'd2, SRC_TERM, J_SEQ, A_RED_TEST, 1'b0);
            A_TERM_MUL + 5'd3: w = uw(OP_MUL_PP, 3'd3, SRC_TERM, J_SEQ, A_RED_TEST, 1'b0);
            A_TERM_RND:        w = uw(OP_MUL_RND, 3'd0, SRC_TERM, J_SEQ, A_RED_TEST, 1'b0);
            A_S_UPD:           w = uw(OP_S_UPD, 3'd0, SRC_TERM, J_K_MORE, A_LOOP, 1'b0);
            A_S_ABS:           w = uw(OP_S_ABS, 3'd0, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_FIN_MUL:         w = uw(OP_MUL_PP, 3'd0, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_FIN_MUL + 5'd1:  w = uw(OP_MUL_PP, 3'd1, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_FIN_MUL + 5'd2:  w = uw(OP_MUL_PP, 3'd2, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_FIN_MUL + 5'd3:  w = uw(OP_MUL_PP, 3'd3, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_FIN_RND:         w = uw(OP_MUL_RND, 3'd0, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_OUT_RND:         w = uw(OP_OUT_RND, 3'd0, SRC_FIN, J_SEQ, A_RED_TEST, 1'b0);
            A_OUT:             w = uw(OP_OUT, 3'd0, SRC_FIN, J_SEQ, A_RED_TEST, 1'b1);
            default:           w = uw(OP_NOP, 3'd0, SRC_SQ, J_SEQ, A_RED_TEST, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/sts_div.sv =====
// ============================================================================
// sts_div : byte-serial divider by a narrow constant
// Long division of a 64-bit word by a 10-bit divisor, one quotient byte per
// step; the quotient replaces the dividend in place.
// ============================================================================
module sts_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          init,
    input  logic                          step,
    input  logic [sts_pkg::WORD_W-1:0]    dividend,
    input  logic [sts_pkg::DIV_W-1:0]     divisor,
    output logic [sts_pkg::WORD_W-1:0]    quotient,
    output logic                          more
);

    localparam int WW    = sts_pkg::WORD_W;
    localparam int DW    = sts_pkg::DIV_W;
    localparam int BYTES = WW / 8;
    localparam int CNT_W = $clog2(BYTES);

    logic [WW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_step;
    logic [7:0]       qbyte;

    // restoring division over the top byte, remainder stays below divisor
    always_comb
    begin
        logic [DW:0]   t;
        logic [DW-1:0] r;
        r     = rem_reg;
        qbyte = '0;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, quo_reg[WW-8+i]};
            if (t >= {1'b0, divisor})
            begin
                r        = DW'(t - {1'b0, divisor});
                qbyte[i] = 1'b1;
            end
            else
            begin
                r = t[DW-1:0];
            end
        end
        rem_step = r;
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (init)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            quo_next = {quo_reg[WW-9:0], qbyte};
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign more     = (cnt_reg != CNT_W'(BYTES - 1));

endmodule

// ===== hw/rtl/sts_dp.sv =====
// ============================================================================
// sts_dp : datapath of the Taylor-series sine block
// Range reduction, a 32x32 multiplier with a partial-product accumulator,
// the Horner sum registers and output rounding, all driven by control words.
// ============================================================================
module sts_dp #(
    parameter int TERMS         = 9,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sts_pkg::ctrl_t       ctrl,
    input  logic signed [31:0]   angle,
    output sts_pkg::stat_t       stat,
    output logic signed [31:0]   sine
);

    localparam int WW    = sts_pkg::WORD_W;
    localparam int WF    = sts_pkg::WFRAC;
    localparam int AW    = sts_pkg::ACC_W;
    localparam int KIW   = sts_pkg::KIDX_W;
    localparam int K_W   = $clog2(TERMS);
    localparam int RSH   = (OUT_FRAC_BITS < WF) ? (WF - OUT_FRAC_BITS) : 0;
    localparam int LSH   = (OUT_FRAC_BITS > WF) ? (OUT_FRAC_BITS - WF) : 0;
    localparam logic [WW-1:0] RND_C   = (64'd1 << RSH) >> 1;
    localparam logic [WW-1:0] ONE_OUT = 64'd1 << OUT_FRAC_BITS;

    logic [WW-1:0]  r_reg, r_next;
    logic [WW-1:0]  xm_reg, xm_next;
    logic           neg_reg, neg_next;
    logic [WW-1:0]  y_reg, y_next;
    logic [WW-1:0]  s_reg, s_next;
    logic           s_neg_reg, s_neg_next;
    logic [WW-1:0]  s_mag_reg, s_mag_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [WW-1:0]  prod_reg, prod_next;
    logic [AW-1:0]  acc_reg, acc_next;
    logic [WW-1:0]  p_reg, p_next;
    logic [WW-1:0]  v_reg, v_next;
    logic [31:0]    sine_reg, sine_next;

    logic [31:0]    ang_u;
    logic [31:0]    mag;
    logic [WW-1:0]  opa, opb;
    logic [31:0]    a_half, b_half;
    logic [WW-1:0]  mul_out;
    logic [WW-1:0]  sub_val;
    logic [WW-1:0]  sat;
    logic [WW-1:0]  quotient;
    logic           div_more;

    sts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (ctrl.op == sts_pkg::OP_DIV_INIT),
        .step     (ctrl.op == sts_pkg::OP_DIV_STEP),
        .dividend (y_reg),
        .divisor  (sts_pkg::divisor(KIW'(k_reg))),
        .quotient (quotient),
        .more     (div_more)
    );

    assign ang_u = angle;
    assign mag   = ang_u[31] ? (32'd0 - ang_u) : ang_u;

    // operand pair and partial-product halves
    always_comb
    begin
        case (ctrl.src)
            sts_pkg::SRC_SQ:
            begin
                opa = xm_reg;
                opb = xm_reg;
            end
            sts_pkg::SRC_TERM:
            begin
                opa = quotient;
                opb = s_mag_reg;
            end
            sts_pkg::SRC_FIN:
            begin
                opa = xm_reg;
                opb = s_mag_reg;
            end
            default:
            begin
                opa = xm_reg;
                opb = xm_reg;
            end
        endcase
        a_half = ctrl.arg[1] ? opa[WW-1:32] : opa[31:0];
        b_half = ctrl.arg[0] ? opb[WW-1:32] : opb[31:0];
    end

    assign mul_out = a_half * b_half;
    assign sub_val = sts_pkg::TWO_PI_Q56 << ctrl.arg;
    assign sat     = (v_reg > ONE_OUT) ? ONE_OUT : v_reg;

    always_comb
    begin
        r_next     = r_reg;
        xm_next    = xm_reg;
        neg_next   = neg_reg;
        y_next     = y_reg;
        s_next     = s_reg;
        s_neg_next = s_neg_reg;
        s_mag_next = s_mag_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        v_next     = v_reg;
        sine_next  = sine_reg;

        if (ctrl.load)
        begin
            r_next   = {mag, 32'd0};
            neg_next = ang_u[31];
        end

        case (ctrl.op)
            sts_pkg::OP_NOP:
            begin
            end
            sts_pkg::OP_RED_TEST:
            begin
                if (r_reg <= sts_pkg::PI_Q56)
                    xm_next = r_reg << 3;
                else
                    r_next = r_reg - sts_pkg::PI_Q56;
            end
            sts_pkg::OP_RED_SUB:
            begin
                if (r_reg >= sub_val)
                    r_next = r_reg - sub_val;
            end
            sts_pkg::OP_RED_FIN:
            begin
                if (r_reg >= sts_pkg::PI_Q56)
                begin
                    xm_next = (r_reg - sts_pkg::PI_Q56) << 3;
                end
                else
                begin
                    xm_next  = (sts_pkg::PI_Q56 - r_reg) << 3;
                    neg_next = !neg_reg;
                end
            end
            sts_pkg::OP_MUL_PP:
            begin
                // product lands in prod_reg, accumulate the previous one
                prod_next = mul_out;
                case (ctrl.arg[1:0])
                    2'd0:    acc_next = acc_reg;
                    2'd1:    acc_next = AW'(prod_reg);
                    default: acc_next = acc_reg + (AW'(prod_reg) << 32);
                endcase
            end
            sts_pkg::OP_MUL_RND:
            begin
                // high partial product folds in above bit 64, round half up
                p_next = WW'(acc_reg[AW-1:WF])
                       + {prod_reg[WF-1:0], {(WW-WF){1'b0}}}
                       + WW'(acc_reg[WF-1]);
            end
            sts_pkg::OP_Y_INIT:
            begin
                y_next = p_reg;
                s_next = sts_pkg::ONE_W;
                k_next = K_W'(TERMS - 1);
            end
            sts_pkg::OP_DIV_INIT,
            sts_pkg::OP_S_ABS:
            begin
                s_neg_next = s_reg[WW-1];
                s_mag_next = s_reg[WW-1] ? (64'd0 - s_reg) : s_reg;
            end
            sts_pkg::OP_DIV_STEP:
            begin
            end
            sts_pkg::OP_S_UPD:
            begin
                s_next = s_neg_reg ? (sts_pkg::ONE_W + p_reg) : (sts_pkg::ONE_W - p_reg);
                k_next = k_reg - K_W'(1);
            end
            sts_pkg::OP_OUT_RND:
            begin
                v_next   = ((p_reg + RND_C) >> RSH) << LSH;
                neg_next = neg_reg ^ s_neg_reg;
            end
            sts_pkg::OP_OUT:
            begin
                sine_next = neg_reg ? 32'(64'd0 - sat) : sat[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        xm_reg    <= xm_next;
        neg_reg   <= neg_next;
        y_reg     <= y_next;
        s_reg     <= s_next;
        s_neg_reg <= s_neg_next;
        s_mag_reg <= s_mag_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        v_reg     <= v_next;
        sine_reg  <= sine_next;
    end

    assign stat.red_small = (r_reg <= sts_pkg::PI_Q56);
    assign stat.div_more  = div_more;
    assign stat.k_more    = (k_reg != K_W'(1));
    assign sine           = $signed(sine_reg);

endmodule

// ===== hw/rtl/sts_seq.sv =====
// ============================================================================
// sts_seq : microcode sequencer
// Step counter over the microprogram ROM, conditional jumps on datapath
// status, command handshake and result strobe.
// ============================================================================
module sts_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sts_pkg::stat_t  stat,
    output logic            busy,
    output logic            done,
    output sts_pkg::ctrl_t  ctrl
);

    localparam int UW = sts_pkg::UPC_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [UW-1:0]    pc_reg, pc_next;
    logic             done_reg, done_next;
    sts_pkg::ucode_t  word;
    logic             take;

    assign word = sts_pkg::urom(pc_reg);

    always_comb
    begin
        case (word.jc)
            sts_pkg::J_SEQ:       take = 1'b0;
            sts_pkg::J_RED_SMALL: take = stat.red_small;
            sts_pkg::J_DIV_MORE:  take = stat.div_more;
            sts_pkg::J_K_MORE:    take = stat.k_more;
            default:              take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    pc_next    = sts_pkg::A_RED_TEST;
                end
            end
            S_RUN:
            begin
                if (word.last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (take)
                begin
                    pc_next = word.jaddr;
                end
                else
                begin
                    pc_next = pc_reg + UW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = (state_reg == S_RUN);
    assign done      = done_reg;
    assign ctrl.load = start && (state_reg == S_IDLE);
    assign ctrl.op   = (state_reg == S_RUN) ? word.op : sts_pkg::OP_NOP;
    assign ctrl.arg  = word.arg;
    assign ctrl.src  = word.src;

endmodule

// ===== hw/rtl/sine_taylor_series.sv =====
// ============================================================================
// sine_taylor_series : sine of a Q8.24 angle by a truncated Taylor series
// Range reduction into [-pi, pi], Horner evaluation of TERMS odd terms and
// rounding to OUT_FRAC_BITS fraction bits, under microcode control.
// ============================================================================
//
//  channel   ports             beat taken when
//  -------   ---------------   ------------------------------------
//  command   start, angle      start high and busy low at clk rise
//  result    done, sine        done high, one cycle, no back-pressure
//
//  A run with |angle| > pi also passes through the range-reduction steps.
//  Each Taylor term passes through the byte-serial divider and then takes
//  4 partial products and 3 steps around the single 32x32 multiplier.
//  busy holds from the command beat until the cycle in which done pulses;
//  a new command is taken in that cycle. Reset clears the sequencer and
//  the divider's byte counter only.
//
module sine_taylor_series #(
    parameter int TERMS         = 9,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  angle,
    output logic                busy,
    output logic                done,
    output logic signed [31:0]  sine
);

    sts_pkg::ctrl_t ctrl;
    sts_pkg::stat_t stat;

    sts_dp #(
        .TERMS         (TERMS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .angle (angle),
        .stat  (stat),
        .sine  (sine)
    );

    sts_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

`ifndef SYNTHESIS
    a_cmd_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command beat did not start a run");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_run_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("run ended without a result beat");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top : testbench for the Taylor-series sine block
// Sends Q8.24 angles through the start/busy command port, predicts each Q1.30
// sine with a bit-exact fixed-point model and checks every done beat against
// it. The run has directed corner angles and then random angles, with phases
// that differ in the gaps between commands.
// ============================================================================
module tb_top;

    localparam int TERMS         = 9;
    localparam int OUT_FRAC_BITS = 30;
    localparam int RANDOM_ANGLES = 550;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [31:0] ang;
        logic [7:0]  gap;   // idle cycles before this command goes out
    } angle_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [31:0] angle = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] sine;

    angle_cmd_t         pending_angles[$];
    logic [31:0]        expected_sines[$];
    logic [31:0]        sent_angles[$];
    logic               cmd_taken = 1'b0;
    int unsigned        gap_left = 0;
    int unsigned        cycle_cnt = 0;
    int unsigned        n_accepted = 0;
    int unsigned        n_checked = 0;
    int unsigned        n_errors = 0;
    int unsigned        n_directed = 0;

    sine_taylor_series #(
        .TERMS         (TERMS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .angle (angle),
        .busy  (busy),
        .done  (done),
        .sine  (sine)
    );

    always #6 clk = ~clk;

    // Rounded (a * b) >> WFRAC on unsigned magnitudes
    function automatic logic [63:0] mul_q59(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[sts_pkg::WFRAC+63:sts_pkg::WFRAC] + {63'd0, p[sts_pkg::WFRAC-1]};
    endfunction

    function automatic logic [31:0] predict_sine(input logic [31:0] raw);
        logic               neg;
        logic               sn;
        logic [31:0]        mag;
        logic [63:0]        m56;
        logic [63:0]        rem;
        logic [63:0]        xm;
        logic [63:0]        y;
        logic [63:0]        d;
        logic [63:0]        t;
        logic [63:0]        smag;
        logic [63:0]        p;
        logic [63:0]        v;
        logic [63:0]        res;
        logic signed [63:0] s;
        int                 k;
        int                 sh;
        neg = raw[31];
        mag = neg ? (~raw + 32'd1) : raw;
        if (mag == 32'd0)
            neg = 1'b0;
        m56 = {mag, 32'd0};
        if (m56 > sts_pkg::PI_Q56)
        begin
            rem = (m56 - sts_pkg::PI_Q56) % sts_pkg::TWO_PI_Q56;
            if (rem >= sts_pkg::PI_Q56)
                xm = (rem - sts_pkg::PI_Q56) << 3;
            else
            begin
                xm = (sts_pkg::PI_Q56 - rem) << 3;
                neg = !neg;
            end
        end
        else
            xm = m56 << 3;

        // Horner in x^2, innermost term first
        y = mul_q59(xm, xm);
        s = $signed(sts_pkg::ONE_W);
        for (k = TERMS - 1; k >= 1; k--)
        begin
            d = 64'((2 * k) * (2 * k + 1));
            t = y / d;
            sn = s[63];
            smag = sn ? (64'd0 - 64'(s)) : 64'(s);
            p = mul_q59(t, smag);
            s = sn ? $signed(sts_pkg::ONE_W + p) : $signed(sts_pkg::ONE_W - p);
        end

        sn = s[63];
        smag = sn ? (64'd0 - 64'(s)) : 64'(s);
        v = mul_q59(xm, smag);
        if (sn)
            neg = !neg;

        if (OUT_FRAC_BITS < sts_pkg::WFRAC)
        begin
            sh = sts_pkg::WFRAC - OUT_FRAC_BITS;
            v = (v + (64'd1 << (sh - 1))) >> sh;
        end
        else if (OUT_FRAC_BITS > sts_pkg::WFRAC)
            v = v << (OUT_FRAC_BITS - sts_pkg::WFRAC);
        if (v > (64'd1 << OUT_FRAC_BITS))
            v = 64'd1 << OUT_FRAC_BITS;
        res = neg ? (64'd0 - v) : v;
        return res[31:0];
    endfunction

    // k quarter turns in Q8.24, rounded
    function automatic logic [31:0] quarter_turn(input int unsigned k);
        logic [79:0] prod;
        prod = 80'(k) * 80'(sts_pkg::PI_Q56);
        prod = (prod + (80'd1 << 32)) >> 33;
        return prod[31:0];
    endfunction

    function automatic logic [31:0] random_angle();
        int unsigned sel;
        logic [31:0] a;
        sel = $urandom_range(99);
        if (sel < 40)
            a = $urandom;
        else if (sel < 70)
        begin
            // land close to a multiple of a quarter turn: zeros, peaks, saturation
            a = quarter_turn($urandom_range(0, 81)) + $urandom_range(0, 8) - 32'd4;
            if ($urandom_range(1))
                a = -a;
        end
        else
        begin
            if ($urandom_range(3) == 0)
                a = $urandom_range(0, 255);
            else
                a = $urandom_range(0, 32'h03243F6B);
            if ($urandom_range(1))
                a = -a;
        end
        return a;
    endfunction

    // Driver: hold a command until it is taken, then advance
    always @(negedge clk)
    begin
        logic        nxt_start;
        logic [31:0] nxt_ang;
        angle_cmd_t  cmd;
        nxt_start = start;
        nxt_ang = angle;
        if (!rst_n)
        begin
            nxt_start = 1'b0;
            nxt_ang = '0;
        end
        else
        begin
            if (start && cmd_taken)
            begin
                nxt_start = 1'b0;
                gap_left = (pending_angles.size() > 0) ? pending_angles[0].gap : 0;
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_angles.size() > 0)
                begin
                    cmd = pending_angles.pop_front();
                    nxt_start = 1'b1;
                    nxt_ang = cmd.ang;
                end
            end
        end
        start <= nxt_start;
        angle <= nxt_ang;
    end

    // Monitor: check the done beat first, then record a new command beat
    always @(posedge clk)
    begin
        logic [31:0] exp_sine;
        logic [31:0] exp_ang;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d sines still awaited",
                     cycle_cnt, expected_sines.size());
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_sines.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: done with no command waiting, sine=%h", $realtime, sine);
                end
                else
                begin
                    exp_sine = expected_sines.pop_front();
                    exp_ang = sent_angles.pop_front();
                    n_checked++;
                    if (sine !== exp_sine)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: angle=%h sine expected %h got %h",
                                     $realtime, exp_ang, exp_sine, sine);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_sines.push_back(predict_sine(angle));
                sent_angles.push_back(angle);
                n_accepted++;
            end
            cmd_taken <= start && !busy;
        end
        else
            cmd_taken <= 1'b0;
    end

    initial
    begin
        logic [31:0] corners[$];
        angle_cmd_t  cmd;
        int unsigned pct;
        int          i;
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0001, 32'h0100_0000, 32'hFF00_0000,
                    32'h0324_3F6A, 32'h0324_3F6B, 32'h0324_3F6C, 32'hFCDB_C095};
        corners.push_back(quarter_turn(1));
        corners.push_back(quarter_turn(1) - 32'd1);
        corners.push_back(-quarter_turn(1));
        corners.push_back(quarter_turn(3));
        corners.push_back(quarter_turn(4));
        corners.push_back(-quarter_turn(4));
        corners.push_back(quarter_turn(80));
        corners.push_back(quarter_turn(81));
        corners.push_back(-quarter_turn(81));
        foreach (corners[j])
        begin
            cmd.ang = corners[j];
            cmd.gap = 8'd0;
            pending_angles.push_back(cmd);
        end
        n_directed = corners.size();

        // Phases: back to back, sparse commands, back to back, light gaps
        for (i = 0; i < RANDOM_ANGLES; i++)
        begin
            case ((i * 4) / RANDOM_ANGLES)
                1:       pct = 49;
                3:       pct = 6;
                default: pct = 0;
            endcase
            cmd.ang = random_angle();
            cmd.gap = ($urandom_range(99) < pct) ? 8'($urandom_range(1, 150)) : 8'd0;
            pending_angles.push_back(cmd);
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_angles.size() > 0 || start || expected_sines.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d angles (%0d directed corners, %0d random), checked %0d sines",
                 n_accepted, n_directed, RANDOM_ANGLES, n_checked);
        $display("Mismatches or stray results: %0d, left unanswered: %0d",
                 n_errors, expected_sines.size());
        if (n_errors == 0 && expected_sines.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
